>>> design/packbits_unit_decoder_core_defines.svh
// assertion helpers for the packbits unit decoder
`ifndef PACKBITS_UNIT_DECODER_CORE_DEFINES_SVH
`define PACKBITS_UNIT_DECODER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define PBUD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define PBUD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/pbud_pkg.sv
package pbud_pkg;

   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned UNIT_W       = 32;
   localparam int unsigned KEPT_BYTES   = UNIT_W / BYTE_W;
   localparam int unsigned COUNT_W      = 8;
   localparam int unsigned CFG_W        = 3;

   localparam logic [BYTE_W-1:0] NOOP_HEADER = 8'd128;
   localparam logic [BYTE_W:0]   REPEAT_BASE = 9'd257;

   typedef struct packed {
      logic [BYTE_W-1:0] code_byte;
      logic              block_last;
   } req_word_type;

   typedef struct packed {
      logic [UNIT_W-1:0]  unit_value;
      logic [COUNT_W-1:0] repeat_count;
      logic               decode_error;
      logic               block_end;
   } rsp_word_type;

endpackage

>>> design/pbud_channels.sv
interface pbud_req_if;
   logic                  valid;
   logic                  ready;
   pbud_pkg::req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface pbud_rsp_if;
   logic                  valid;
   logic                  ready;
   pbud_pkg::rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface pbud_csr_if;
   logic                          valid;
   logic                          ready;
   logic [pbud_pkg::CFG_W-1:0]    unit_bytes;

   modport source (output valid, output unit_bytes, input ready);
   modport sink   (input valid, input unit_bytes, output ready);
endinterface

>>> design/packbits_unit_decoder_core.sv
// PackBits decoder over data units of 1 to MAX_UNIT_BYTES bytes (unit_bytes register,
// 0 acts as 1, larger values clamp). One compressed byte is taken per cycle while no result
// is held waiting on rsp, and its result is registered; a result waiting on rsp does not
// block the next byte as long as rsp_ready is high, the single output register being the
// only buffering. A literal header n (0..127) brings n+1 units, each reported with repeat
// count 1; a header h above 128 brings one unit reported with count 257-h; header 128 is
// skipped. A byte marked block_last always yields a result with block_end set, and
// decode_error set when the block stopped inside a run; only the first four bytes of a
// unit are kept in unit_value. Write unit_bytes only while the decoder is idle.
`include "packbits_unit_decoder_core_defines.svh"

module packbits_unit_decoder_core #(
   parameter int unsigned MAX_UNIT_BYTES = 4
) (
   input  logic       clock,
   input  logic       reset,
   pbud_req_if.sink   req_chan,
   pbud_rsp_if.source rsp_chan,
   pbud_csr_if.sink   csr_chan
);

   localparam int unsigned POS_W = (MAX_UNIT_BYTES > 1) ? $clog2(MAX_UNIT_BYTES) : 1;
   localparam logic [3:0]  MAX_SIZE = 4'(MAX_UNIT_BYTES);

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_LITERAL = 2'd1;
   localparam logic [1:0] PH_REPEAT  = 2'd2;

   logic [pbud_pkg::CFG_W-1:0]   unit_bytes_ff, unit_bytes_in;
   logic [1:0]                   phase_ff, phase_in;
   logic [pbud_pkg::COUNT_W-1:0] units_ff, units_in;
   logic [pbud_pkg::COUNT_W-1:0] run_ff, run_in;
   logic [POS_W-1:0]             byte_pos_ff, byte_pos_in;
   logic [pbud_pkg::UNIT_W-1:0]  assembly_ff, assembly_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   pbud_pkg::rsp_word_type       rsp_word_ff, rsp_word_in;

   logic                         req_accept;
   logic [3:0]                   size_eff;
   logic [3:0]                   pos_inc;
   logic                         unit_done;
   logic [pbud_pkg::UNIT_W-1:0]  assembled;
   logic [pbud_pkg::BYTE_W-1:0]  code_byte;
   logic                         emit;
   logic [pbud_pkg::COUNT_W-1:0] units_dec;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.word  = rsp_word_ff;
   assign code_byte      = req_chan.word.code_byte;

   always_comb begin
      unit_bytes_in = unit_bytes_ff;
      if (csr_chan.valid) begin
         unit_bytes_in = csr_chan.unit_bytes;
      end
   end

   // effective unit size and byte lane merge
   always_comb begin
      if (unit_bytes_ff == '0) begin
         size_eff = 4'd1;
      end else if (4'(unit_bytes_ff) > MAX_SIZE) begin
         size_eff = MAX_SIZE;
      end else begin
         size_eff = 4'(unit_bytes_ff);
      end
      pos_inc   = 4'(byte_pos_ff) + 4'd1;
      unit_done = (pos_inc >= size_eff);
      assembled = assembly_ff;
      for (int k = 0; k < pbud_pkg::KEPT_BYTES; k++) begin
         if (4'(byte_pos_ff) == 4'(k)) begin
            assembled[8*k +: 8] = assembly_ff[8*k +: 8] | code_byte;
         end
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      units_in     = units_ff;
      run_in       = run_ff;
      byte_pos_in  = byte_pos_ff;
      assembly_in  = assembly_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      emit         = 1'b0;
      units_dec    = (units_ff != '0) ? units_ff - 8'd1 : units_ff;

      if (req_accept) begin
         rsp_word_in = '0;
         unique case (phase_ff) inside
            PH_HEADER: begin
               if (!code_byte[7]) begin
                  phase_in    = PH_LITERAL;
                  units_in    = code_byte + 8'd1;
                  byte_pos_in = '0;
                  assembly_in = '0;
               end else if (code_byte != pbud_pkg::NOOP_HEADER) begin
                  phase_in    = PH_REPEAT;
                  run_in      = 8'(pbud_pkg::REPEAT_BASE - {1'b0, code_byte});
                  byte_pos_in = '0;
                  assembly_in = '0;
               end
            end
            PH_LITERAL, PH_REPEAT: begin
               if (unit_done) begin
                  emit                   = 1'b1;
                  rsp_word_in.unit_value = assembled;
                  assembly_in            = '0;
                  byte_pos_in            = '0;
                  if (phase_ff == PH_LITERAL) begin
                     rsp_word_in.repeat_count = 8'd1;
                     units_in                 = units_dec;
                     if (units_dec == '0) begin
                        phase_in = PH_HEADER;
                     end
                  end else begin
                     rsp_word_in.repeat_count = run_ff;
                     run_in                   = '0;
                     phase_in                 = PH_HEADER;
                  end
               end else begin
                  byte_pos_in = POS_W'(pos_inc);
                  assembly_in = assembled;
               end
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase

         if (req_chan.word.block_last) begin
            rsp_word_in.decode_error = (phase_in != PH_HEADER);
            rsp_word_in.block_end    = 1'b1;
            phase_in                 = PH_HEADER;
            units_in                 = '0;
            run_in                   = '0;
            byte_pos_in              = '0;
            assembly_in              = '0;
         end

         if (emit || req_chan.word.block_last) begin
            rsp_valid_in = 1'b1;
         end else begin
            rsp_word_in = rsp_word_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_bytes_ff <= 3'd1;
         phase_ff      <= PH_HEADER;
         units_ff      <= '0;
         run_ff        <= '0;
         byte_pos_ff   <= '0;
         assembly_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         unit_bytes_ff <= unit_bytes_in;
         phase_ff      <= phase_in;
         units_ff      <= units_in;
         run_ff        <= run_in;
         byte_pos_ff   <= byte_pos_in;
         assembly_ff   <= assembly_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   `PBUD_ASSERT_NOW(a_empty_unit_zero, rsp_valid_ff && rsp_word_ff.repeat_count == 8'd0, rsp_word_ff.unit_value == '0, "unit value set without a unit")
   `PBUD_ASSERT_NOW(a_error_on_end, rsp_valid_ff && rsp_word_ff.decode_error, rsp_word_ff.block_end, "decode error outside block end")
   `PBUD_ASSERT_NOW(a_literal_pending, phase_ff == PH_LITERAL, units_ff != '0, "literal run with no units left")
   `PBUD_ASSERT_NEXT(a_block_clears, req_accept && req_chan.word.block_last, phase_ff == PH_HEADER && byte_pos_ff == '0 && assembly_ff == '0, "run state kept past block end")

endmodule

>>> sim/packbits_unit_decoder_core_tb.sv
module packbits_unit_decoder_core_tb;

   localparam int MAX_UNIT_BYTES = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;

   typedef enum logic [1:0] {
      AWAIT_HEADER,
      LITERAL_RUN,
      REPEAT_RUN
   } run_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pbud_req_if req_if();
   pbud_rsp_if rsp_if();
   pbud_csr_if csr_if();

   packbits_unit_decoder_core #(
      .MAX_UNIT_BYTES(MAX_UNIT_BYTES)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #2 clock = ~clock;

   // decoder state as predicted
   run_phase_type dec_phase = AWAIT_HEADER;
   int            units_left = 0;
   int            pending_count = 0;
   int            byte_pos = 0;
   logic [31:0]   assembly = '0;
   logic [2:0]    unit_bytes_reg = 3'd1;

   pbud_pkg::rsp_word_type expected_units[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatches = 0;
   int bytes_sent = 0;
   int results_seen = 0;
   int error_blocks = 0;
   int repeat_units = 0;
   int idle_cycles = 0;

   function automatic int unit_size();
      if (unit_bytes_reg == 3'd0) return 1;
      if (int'(unit_bytes_reg) > MAX_UNIT_BYTES) return MAX_UNIT_BYTES;
      return int'(unit_bytes_reg);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   // one compressed byte in, predicted word queued when one is due
   task automatic send_code(input logic [7:0] code, input logic last);
      pbud_pkg::rsp_word_type r;
      logic emit;
      int pos;
      req_if.valid <= 1'b1;
      req_if.word <= '{code_byte: code, block_last: last};
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      bytes_sent++;
      emit = 1'b0;
      r = '0;
      if (dec_phase == AWAIT_HEADER) begin
         if (code < pbud_pkg::NOOP_HEADER) begin
            dec_phase = LITERAL_RUN;
            units_left = int'(code) + 1;
            byte_pos = 0;
            assembly = '0;
         end else if (code > pbud_pkg::NOOP_HEADER) begin
            dec_phase = REPEAT_RUN;
            pending_count = int'(pbud_pkg::REPEAT_BASE) - int'(code);
            byte_pos = 0;
            assembly = '0;
         end
      end else begin
         pos = byte_pos;
         if (pos < 4) assembly[8*pos +: 8] = code;
         pos++;
         if (pos >= unit_size()) begin
            emit = 1'b1;
            r.unit_value = assembly;
            assembly = '0;
            byte_pos = 0;
            if (dec_phase == LITERAL_RUN) begin
               r.repeat_count = 8'd1;
               if (units_left > 0) units_left--;
               if (units_left == 0) dec_phase = AWAIT_HEADER;
            end else begin
               r.repeat_count = pending_count[7:0];
               pending_count = 0;
               dec_phase = AWAIT_HEADER;
               repeat_units++;
            end
         end else begin
            byte_pos = pos;
         end
      end
      if (last) begin
         r.decode_error = (dec_phase != AWAIT_HEADER);
         r.block_end = 1'b1;
         if (r.decode_error) error_blocks++;
         dec_phase = AWAIT_HEADER;
         units_left = 0;
         pending_count = 0;
         byte_pos = 0;
         assembly = '0;
      end
      if (emit || last) expected_units.push_back(r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // sender holds off until every expected word is back
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_units.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_unit_bytes(input logic [2:0] value);
      csr_if.valid <= 1'b1;
      csr_if.unit_bytes <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      unit_bytes_reg = value;
      csr_if.valid <= 1'b0;
   endtask

   task automatic send_random_block();
      logic [7:0] stream[$];
      int runs;
      int kind;
      int n;
      stream = {};
      if ($urandom_range(9) == 0) begin
         n = $urandom_range(1, 8);
         repeat (n) stream.push_back(8'($urandom_range(255)));
      end else begin
         runs = $urandom_range(1, 4);
         repeat (runs) begin
            kind = $urandom_range(9);
            if (kind < 6) begin
               n = ($urandom_range(19) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 3);
               stream.push_back(8'(n));
               repeat ((n + 1) * unit_size()) stream.push_back(8'($urandom_range(255)));
            end else if (kind < 9) begin
               stream.push_back(8'($urandom_range(129, 255)));
               repeat (unit_size()) stream.push_back(8'($urandom_range(255)));
            end else begin
               stream.push_back(pbud_pkg::NOOP_HEADER);
            end
         end
         if (stream.size() > 1 && $urandom_range(99) < 15)
            stream = stream[0:$urandom_range(0, stream.size() - 2)];
      end
      foreach (stream[i]) send_code(stream[i], i == stream.size() - 1);
   endtask

   task automatic test_directed_headers();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_code(pbud_pkg::NOOP_HEADER, 1'b0);
      send_code(8'd0, 1'b0);
      send_code(8'h00, 1'b0);
      send_code(8'd127, 1'b0);
      send_code(8'hff, 1'b0);
      send_code(8'h80, 1'b0);
      send_code(8'h01, 1'b1);
      send_code(8'd129, 1'b0);
      send_code(8'ha5, 1'b0);
      send_code(8'd255, 1'b0);
      send_code(8'h5a, 1'b0);
      send_code(pbud_pkg::NOOP_HEADER, 1'b1);
      send_code(8'd200, 1'b1);
      send_code(8'd1, 1'b0);
      send_code(8'h11, 1'b0);
      send_code(8'h22, 1'b1);
      send_code(8'd254, 1'b0);
      send_code(8'h7f, 1'b1);
      wait_idle();
      write_unit_bytes(3'd4);
      send_code(8'h81, 1'b0);
      send_code(8'h12, 1'b0);
      send_code(8'h34, 1'b0);
      send_code(8'h56, 1'b0);
      send_code(8'h78, 1'b1);
      send_code(8'd0, 1'b0);
      send_code(8'hee, 1'b1);
      wait_idle();
   endtask

   task automatic test_unit_size_sweep();
      for (int v = 0; v < 8; v++) begin
         write_unit_bytes(3'(v));
         send_code(8'd1, 1'b0);
         repeat (2 * unit_size()) send_code(8'($urandom_range(255)), 1'b0);
         send_code(8'($urandom_range(129, 255)), 1'b0);
         for (int i = 0; i < unit_size(); i++)
            send_code(8'($urandom_range(255)), i == unit_size() - 1);
         wait_idle();
      end
   endtask

   task automatic test_random_streams();
      int idle_mix[4][2];
      logic [2:0] sizes[4];
      int start;
      logic paused;
      idle_mix = '{'{0, 0}, '{86, 0}, '{0, 86}, '{31, 31}};
      sizes = '{3'd4, 3'd1, 3'd7, 3'd0};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_mix[p][0];
         rsp_stall_pct = idle_mix[p][1];
         write_unit_bytes(($urandom_range(3) == 0) ? 3'($urandom_range(7)) : sizes[p]);
         start = bytes_sent;
         paused = 1'b0;
         while (bytes_sent - start < 90) begin
            send_random_block();
            if (!paused && bytes_sent - start > 45) begin
               wait_idle();
               paused = 1'b1;
            end
            if ($urandom_range(5) == 0) begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end else begin
               send_idle_pct = idle_mix[p][0];
               rsp_stall_pct = idle_mix[p][1];
            end
         end
         wait_idle();
      end
   endtask

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      pbud_pkg::rsp_word_type want;
      pbud_pkg::rsp_word_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.word;
         results_seen++;
         if (expected_units.size() == 0) begin
            report_mismatch($sformatf("word with nothing expected: %h", got));
         end else begin
            want = expected_units.pop_front();
            if (got.unit_value !== want.unit_value)
               report_mismatch($sformatf("unit_value expected %h got %h",
                  want.unit_value, got.unit_value));
            if (got.repeat_count !== want.repeat_count)
               report_mismatch($sformatf("repeat_count expected %0d got %0d",
                  want.repeat_count, got.repeat_count));
            if (got.decode_error !== want.decode_error)
               report_mismatch($sformatf("decode_error expected %b got %b",
                  want.decode_error, got.decode_error));
            if (got.block_end !== want.block_end)
               report_mismatch($sformatf("block_end expected %b got %b",
                  want.block_end, got.block_end));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (csr_if.valid && csr_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d words outstanding",
               WATCHDOG_LIMIT, expected_units.size());
            $display("FAIL packbits_unit_decoder_core");
            $finish;
         end
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.word = '0;
      csr_if.valid = 1'b0;
      csr_if.unit_bytes = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_headers();
      test_unit_size_sweep();
      test_random_streams();
      wait_idle();
      $display("covered %0d code bytes, %0d result words checked, all unit sizes 0 to 7",
         bytes_sent, results_seen);
      $display("%0d repeat units, %0d blocks ending inside a run, %0d mismatches",
         repeat_units, error_blocks, mismatches);
      if (mismatches == 0) begin
         $display("PASS packbits_unit_decoder_core");
      end else begin
         $display("FAIL packbits_unit_decoder_core");
      end
      $finish;
   end

endmodule
